FILE: hdl/fire_effect_grid_engine_assert.svh
// Assertion macros for the fire effect grid engine; empty when synthesized.
`ifndef FIRE_EFFECT_GRID_ENGINE_ASSERT_SVH
`define FIRE_EFFECT_GRID_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define FEGE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fire effect grid engine: same-cycle check failed");
`define FEGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fire effect grid engine: next-cycle check failed");
`else
`define FEGE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FEGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/fege_pkg.sv
// Shared constants, codes and the color palette of the fire effect grid engine.
package fege_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int LEVEL_W  = 6;
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 6;
    localparam int CFG_DW   = 7;
    localparam int CFG_IW   = 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd36;
    localparam logic [LEVEL_W-1:0] DIM_STEP  = 6'd2;

    localparam logic [CFG_DW-1:0] CFG_RESET = 7'd64;
    localparam logic [CFG_IW-1:0] CFG_COLS  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_ROWS  = 1'b1;

    localparam logic [1:0] MODE_IGNITE = 2'd0;
    localparam logic [1:0] MODE_DIM    = 2'd1;
    localparam logic [1:0] MODE_SPREAD = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [1:0] SHIFT_RIGHT = 2'd0;
    localparam logic [1:0] SHIFT_LEFT  = 2'd2;
    localparam logic [1:0] SHIFT_BAD   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_SHIFT_BAD = 2'd1;
    localparam logic [1:0] ST_COORD_BAD = 2'd2;

    typedef logic [3*COLOR_W-1:0] t_rgb;

    // Fire palette, dark gray through red and yellow to white.
    function automatic t_rgb palette_rgb(input logic [LEVEL_W-1:0] lvl);
        t_rgb rgb;
        case (lvl)
            6'd0:    rgb = 24'h070707;
            6'd1:    rgb = 24'h1F0707;
            6'd2:    rgb = 24'h2F0F07;
            6'd3:    rgb = 24'h470F07;
            6'd4:    rgb = 24'h571707;
            6'd5:    rgb = 24'h671F07;
            6'd6:    rgb = 24'h771F07;
            6'd7:    rgb = 24'h8F2707;
            6'd8:    rgb = 24'h9F2F07;
            6'd9:    rgb = 24'hAF3F07;
            6'd10:   rgb = 24'hBF4707;
            6'd11:   rgb = 24'hC74707;
            6'd12:   rgb = 24'hDF4F07;
            6'd13:   rgb = 24'hDF5707;
            6'd14:   rgb = 24'hDF5707;
            6'd15:   rgb = 24'hD75F07;
            6'd16:   rgb = 24'hD75F07;
            6'd17:   rgb = 24'hD7670F;
            6'd18:   rgb = 24'hCF6F0F;
            6'd19:   rgb = 24'hCF770F;
            6'd20:   rgb = 24'hCF7F0F;
            6'd21:   rgb = 24'hCF8717;
            6'd22:   rgb = 24'hC78717;
            6'd23:   rgb = 24'hC78F17;
            6'd24:   rgb = 24'hC7971F;
            6'd25:   rgb = 24'hBF9F1F;
            6'd26:   rgb = 24'hBF9F1F;
            6'd27:   rgb = 24'hBFA727;
            6'd28:   rgb = 24'hBFA727;
            6'd29:   rgb = 24'hBFAF2F;
            6'd30:   rgb = 24'hB7AF2F;
            6'd31:   rgb = 24'hB7B72F;
            6'd32:   rgb = 24'hB7B737;
            6'd33:   rgb = 24'hCFCF6F;
            6'd34:   rgb = 24'hDFDF9F;
            6'd35:   rgb = 24'hEFEFC7;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

FILE: hdl/fege_heat_mem.sv
// Single-port-write, registered-read heat level memory.
module fege_heat_mem
    import fege_pkg::*;
#(
    parameter int AW = 12,
    parameter int DW = LEVEL_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fege_seq.sv
// Sequencer: clearing pass, row walks, spread and read over the heat memory.
`include "fire_effect_grid_engine_assert.svh"
module fege_seq
    import fege_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int CW   = $clog2(MAX_COLS),
    parameter int RW   = $clog2(MAX_ROWS),
    parameter int CCW  = $clog2(MAX_COLS + 1),
    parameter int RCW  = $clog2(MAX_ROWS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_mode,
    input  logic [COORD_W-1:0]   i_row,
    input  logic [COORD_W-1:0]   i_column,
    input  logic                 i_dim_bit,
    input  logic [1:0]           i_shift,
    input  logic [CCW-1:0]       i_cols,
    input  logic [RCW-1:0]       i_rows,
    output logic                 o_mem_we,
    output logic [RW+CW-1:0]     o_mem_waddr,
    output logic [LEVEL_W-1:0]   o_mem_wdata,
    output logic [RW+CW-1:0]     o_mem_raddr,
    input  logic [LEVEL_W-1:0]   i_mem_rdata,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [LEVEL_W-1:0]   o_level,
    output logic [COLOR_W-1:0]   o_red,
    output logic [COLOR_W-1:0]   o_green,
    output logic [COLOR_W-1:0]   o_blue
);

    localparam int AW = RW + CW;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_WALK  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CW-1:0]      r_walk, n_walk;
    logic [1:0]         r_mode, n_mode;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_col, n_col;
    logic               r_dim, n_dim;
    logic [1:0]         r_shift, n_shift;
    logic               r_valid, n_valid;
    logic [1:0]         r_status, n_status;
    logic [LEVEL_W-1:0] r_level, n_level;
    t_rgb               r_rgb, n_rgb;

    logic               accept;
    logic [RW-1:0]      bottom;
    logic               coord_bad;
    logic               shift_bad;
    logic               walk_last;
    logic [LEVEL_W-1:0] rd_level;
    logic [CW-1:0]      tgt_col;
    logic [RW-1:0]      row_up;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign bottom = RW'(32'(i_rows) - 32'd1);

    assign coord_bad = (32'(r_row) >= 32'(i_rows)) || (32'(r_col) >= 32'(i_cols));
    assign shift_bad = (r_shift == SHIFT_BAD)
                    || (r_shift == SHIFT_LEFT && r_col == '0)
                    || (r_shift == SHIFT_RIGHT && (32'(r_col) + 32'd1 >= 32'(i_cols)));
    assign walk_last = (32'(r_walk) == 32'(i_cols) - 32'd1);
    assign rd_level  = (i_mem_rdata > LEVEL_MAX) ? LEVEL_MAX : i_mem_rdata;
    assign tgt_col   = CW'(32'(r_col) + 32'd1 - 32'(r_shift));
    assign row_up    = RW'(32'(r_row) - 32'd1);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_walk      = r_walk;
        n_mode      = r_mode;
        n_row       = r_row;
        n_col       = r_col;
        n_dim       = r_dim;
        n_shift     = r_shift;
        n_valid     = 1'b0;
        n_status    = ST_DONE;
        n_level     = '0;
        n_rgb       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = {row_up, CW'(r_col)};
        o_mem_wdata = '0;
        o_mem_raddr = {RW'(i_row), CW'(i_column)};

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_mode == MODE_IGNITE || i_mode == MODE_DIM) begin
                    o_mem_raddr = {bottom, CW'(0)};
                end
                if (accept) begin
                    n_mode  = i_mode;
                    n_row   = i_row;
                    n_col   = i_column;
                    n_dim   = i_dim_bit;
                    n_shift = i_shift;
                    n_walk  = '0;
                    n_state = (i_mode == MODE_IGNITE || i_mode == MODE_DIM) ? S_WALK : S_EXEC;
                end
            end
            S_WALK: begin
                // Write column r_walk while the next column's read is in flight.
                o_mem_we    = 1'b1;
                o_mem_waddr = {bottom, r_walk};
                o_mem_raddr = {bottom, r_walk + CW'(1)};
                if (r_mode == MODE_IGNITE) begin
                    o_mem_wdata = LEVEL_MAX;
                end else begin
                    o_mem_wdata = (i_mem_rdata >= DIM_STEP) ? i_mem_rdata - DIM_STEP : '0;
                end
                if (walk_last) begin
                    n_walk  = '0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_walk = r_walk + CW'(1);
                end
            end
            S_EXEC: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (coord_bad) begin
                    n_status = ST_COORD_BAD;
                end else if (r_mode == MODE_READ) begin
                    n_level = rd_level;
                    n_rgb   = palette_rgb(rd_level);
                end else if (r_row != '0) begin
                    if (i_mem_rdata == '0) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = {row_up, CW'(r_col)};
                        o_mem_wdata = '0;
                    end else if (shift_bad) begin
                        n_status = ST_SHIFT_BAD;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = {row_up, tgt_col};
                        o_mem_wdata = i_mem_rdata - LEVEL_W'(r_dim);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_walk  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_walk  <= n_walk;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_row    <= n_row;
        r_col    <= n_col;
        r_dim    <= n_dim;
        r_shift  <= n_shift;
        r_status <= n_status;
        r_level  <= n_level;
        r_rgb    <= n_rgb;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_level  = r_level;
    assign o_red    = r_rgb[3*COLOR_W-1:2*COLOR_W];
    assign o_green  = r_rgb[2*COLOR_W-1:COLOR_W];
    assign o_blue   = r_rgb[COLOR_W-1:0];

    `FEGE_ASSERT_IMPLY(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !o_mem_we)
    `FEGE_ASSERT_NEXT(a_no_result_from_idle, i_clk, i_rst_n, r_state == S_IDLE || r_state == S_CLEAR, !r_valid)
    `FEGE_ASSERT_IMPLY(a_walk_in_grid, i_clk, i_rst_n, r_state == S_WALK, 32'(r_walk) < 32'(i_cols))
    `FEGE_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, accept, r_state == S_EXEC || r_state == S_WALK)

endmodule

FILE: hdl/fire_effect_grid_engine.sv
// Top level of the fire effect grid engine: configuration registers, sequencer and heat memory.
// Spread and read: the heat memory read is issued as the beat is taken; the next step writes
// back and registers the result, shown on o_valid the cycle after; busy drops in that cycle.
// Ignite and dim make one memory write per bottom-row column.
// After reset a clearing pass writes every memory entry once, 2**(clog2 rows + clog2 cols)
// entries (4096 at default size), with busy high. The receiver cannot stall results.
module fire_effect_grid_engine
    import fege_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_column,
    input  logic               i_dim_bit,
    input  logic [1:0]         i_shift,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [LEVEL_W-1:0] o_level,
    output logic [COLOR_W-1:0] o_red,
    output logic [COLOR_W-1:0] o_green,
    output logic [COLOR_W-1:0] o_blue
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int AW  = RW + CW;

    // Raw register values as written; the grid size used is clamped below.
    logic [CFG_DW-1:0] r_cols_cfg;
    logic [CFG_DW-1:0] r_rows_cfg;
    logic [CCW-1:0]    cols_eff;
    logic [RCW-1:0]    rows_eff;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [LEVEL_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [LEVEL_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= CFG_RESET;
            r_rows_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLS: r_cols_cfg <= i_cfg_data;
                CFG_ROWS: r_rows_cfg <= i_cfg_data;
            endcase
        end
    end

    // A count of zero acts as one, and a count above the grid size acts as the grid size.
    always_comb begin
        if (r_cols_cfg == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_cols_cfg) > 32'(MAX_COLS)) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(r_cols_cfg);
        end
        if (r_rows_cfg == '0) begin
            rows_eff = RCW'(1);
        end else if (32'(r_rows_cfg) > 32'(MAX_ROWS)) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(r_rows_cfg);
        end
    end

    // The sequencer owns every memory access; each beat yields exactly one result.
    fege_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW),
        .CCW      (CCW),
        .RCW      (RCW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_dim_bit   (i_dim_bit),
        .i_shift     (i_shift),
        .i_cols      (cols_eff),
        .i_rows      (rows_eff),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_level     (o_level),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    // Cells are addressed as {row, column}; columns past the count in use are written only by the clearing pass.
    fege_heat_mem #(
        .AW (AW),
        .DW (LEVEL_W)
    ) u_heat_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the fire effect grid engine, with its own heat grid predictor.
`timescale 1ns / 1ps

module tb_top
    import fege_pkg::*;
();

    // The straight-up shift has no name in the package.
    localparam logic [1:0] SHIFT_UP = 2'd1;

    // Cycles without any accepted beat or result before the run is declared hung. The limit
    // must outlast the clearing pass after reset, a row walk and the longest sender gap.
    localparam int WATCHDOG_LIMIT = 20000;

    // Cycles to keep watching after the last expected result, covering a full row walk.
    localparam int DRAIN_CYCLES = 80;

    // Fire palette, level 36 in the top bits down to level 0 in the bottom bits.
    localparam logic [37*24-1:0] FIRE_COLORS = {
        24'hFFFFFF, 24'hEFEFC7, 24'hDFDF9F, 24'hCFCF6F, 24'hB7B737, 24'hB7B72F,
        24'hB7AF2F, 24'hBFAF2F, 24'hBFA727, 24'hBFA727, 24'hBF9F1F, 24'hBF9F1F,
        24'hC7971F, 24'hC78F17, 24'hC78717, 24'hCF8717, 24'hCF7F0F, 24'hCF770F,
        24'hCF6F0F, 24'hD7670F, 24'hD75F07, 24'hD75F07, 24'hDF5707, 24'hDF5707,
        24'hDF4F07, 24'hC74707, 24'hBF4707, 24'hAF3F07, 24'h9F2F07, 24'h8F2707,
        24'h771F07, 24'h671F07, 24'h571707, 24'h470F07, 24'h2F0F07,
        24'h1F0707, 24'h070707
    };

    typedef struct packed {
        logic [1:0]         mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic               dim_bit;
        logic [1:0]         shift;
    } t_fire_op;

    typedef struct packed {
        logic [1:0]         status;
        logic [LEVEL_W-1:0] level;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_fire_res;

    // Clock, reset and every block input start at known values.
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0]  i_cfg_index = CFG_COLS;
    logic [CFG_DW-1:0]  i_cfg_data  = '0;
    logic               start       = 1'b0;
    logic [1:0]         i_mode      = MODE_READ;
    logic [COORD_W-1:0] i_row       = '0;
    logic [COORD_W-1:0] i_column    = '0;
    logic               i_dim_bit   = 1'b0;
    logic [1:0]         i_shift     = SHIFT_UP;

    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [LEVEL_W-1:0] o_level;
    logic [COLOR_W-1:0] o_red;
    logic [COLOR_W-1:0] o_green;
    logic [COLOR_W-1:0] o_blue;

    fire_effect_grid_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_dim_bit   (i_dim_bit),
        .i_shift     (i_shift),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_level     (o_level),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always #6 i_clk = ~i_clk;

    // Items waiting to be driven, and results predicted but not yet seen.
    t_fire_op  op_backlog[$];
    t_fire_res pending_results[$];

    // Predictor state: its own heat grid and copies of the two count registers.
    logic [LEVEL_W-1:0] heat_grid [0:DEF_MAX_ROWS-1][0:DEF_MAX_COLS-1];
    logic [CFG_DW-1:0]  cols_reg = CFG_RESET;
    logic [CFG_DW-1:0]  rows_reg = CFG_RESET;

    // Handshake bookkeeping of the monitor and the driver; only beat_taken is shared between them.
    logic beat_taken  = 1'b0;
    int   idle_cycles = 0;
    int   burst_left  = 1;
    int   gap_left    = 0;

    // Run statistics.
    int error_count   = 0;
    int results_seen  = 0;
    int grid_settings = 0;
    int mode_count    [0:3];
    int status_count  [0:3];

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH at result %0d: %s is %0d, expected %0d", results_seen, what, got,
                 want);
    endtask

    // A count register of 0 behaves as 1 and anything above the grid size as the grid size.
    function automatic int effective_count(input logic [CFG_DW-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Applies one beat to the predicted grid and returns the result the block should give.
    task automatic apply_fire_op(input t_fire_op op, output t_fire_res res);
        int                 cols;
        int                 rows;
        int                 bottom;
        int                 target;
        logic [LEVEL_W-1:0] src;
        cols   = effective_count(cols_reg, DEF_MAX_COLS);
        rows   = effective_count(rows_reg, DEF_MAX_ROWS);
        bottom = rows - 1;
        res    = '0;
        if (op.mode == MODE_IGNITE || op.mode == MODE_DIM) begin
            // Both walk the bottom row in use; dim saturates at zero.
            for (int c = 0; c < cols; c++) begin
                if (op.mode == MODE_IGNITE) begin
                    heat_grid[bottom][c] = LEVEL_MAX;
                end else begin
                    heat_grid[bottom][c] = (heat_grid[bottom][c] >= DIM_STEP) ?
                                           heat_grid[bottom][c] - DIM_STEP : '0;
                end
            end
            res.status = ST_DONE;
        end else if (op.row >= rows || op.column >= cols) begin
            res.status = ST_COORD_BAD;
        end else if (op.mode == MODE_SPREAD) begin
            res.status = ST_DONE;
            // The top row has nothing above it, so spreading from it is a no-op.
            if (op.row > 0) begin
                src = heat_grid[op.row][op.column];
                if (src == 0) begin
                    // A cold cell puts out the cell straight above, whatever the shift.
                    heat_grid[op.row - 1][op.column] = '0;
                end else if (op.shift == SHIFT_BAD ||
                             (op.shift == SHIFT_LEFT && op.column == 0) ||
                             (op.shift == SHIFT_RIGHT && op.column + 1 >= cols)) begin
                    res.status = ST_SHIFT_BAD;
                end else begin
                    target = op.column + 1 - op.shift;
                    heat_grid[op.row - 1][target] = src - op.dim_bit;
                end
            end
        end else begin
            res.status = ST_DONE;
            res.level  = heat_grid[op.row][op.column];
            if (res.level > LEVEL_MAX) res.level = LEVEL_MAX;
            {res.red, res.green, res.blue} = FIRE_COLORS[res.level * 24 +: 24];
        end
    endtask

    // Monitor: samples at the rising edge. The result of an earlier beat is checked before a
    // beat accepted at the same edge is predicted, which keeps the predictor in block order.
    always @(posedge i_clk) begin
        t_fire_res want;
        t_fire_res got;
        t_fire_op  op;
        if (!i_rst_n) begin
            beat_taken = 1'b0;
        end else begin
            beat_taken = start && !busy;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COLS) cols_reg = i_cfg_data;
                else rows_reg = i_cfg_data;
            end
            if (o_valid) begin
                results_seen++;
                got = {o_status, o_level, o_red, o_green, o_blue};
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result, status", o_status, -1);
                end else begin
                    want = pending_results.pop_front();
                    status_count[want.status]++;
                    if (got.status !== want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.level !== want.level)
                        flag_mismatch("level", got.level, want.level);
                    if (got.red !== want.red)
                        flag_mismatch("red", got.red, want.red);
                    if (got.green !== want.green)
                        flag_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue)
                        flag_mismatch("blue", got.blue, want.blue);
                end
            end
            if (beat_taken) begin
                op = '{i_mode, i_row, i_column, i_dim_bit, i_shift};
                mode_count[op.mode]++;
                apply_fire_op(op, want);
                pending_results.push_back(want);
            end
            if (o_valid || beat_taken) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Driver: changes inputs at the falling edge. A raised start is held until the block takes
    // the beat; the sender then works in bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        t_fire_op op;
        if (i_rst_n && !(start && !beat_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (op_backlog.size() > 0) begin
                op = op_backlog.pop_front();
                i_mode    <= op.mode;
                i_row     <= op.row;
                i_column  <= op.column;
                i_dim_bit <= op.dim_bit;
                i_shift   <= op.shift;
                start     <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    // Mostly short bursts, now and then a long stretch with no gap at all.
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 8);
                    case ($urandom_range(0, 9))
                        0:       gap_left = $urandom_range(20, 80);
                        1, 2, 3: gap_left = 0;
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic queue_op(input logic [1:0] mode, input int row, input int column,
                            input logic dim_bit, input logic [1:0] shift);
        op_backlog.push_back('{mode, row[COORD_W-1:0], column[COORD_W-1:0], dim_bit, shift});
    endtask

    // Waits until nothing is queued, driven or outstanding and the block is idle.
    task automatic wait_drained();
        while (op_backlog.size() != 0 || start || pending_results.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    // Writes both count registers; only called while the block is idle.
    task automatic set_grid(input logic [CFG_DW-1:0] cols, input logic [CFG_DW-1:0] rows);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= cols;
        @(negedge i_clk);
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= rows;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        grid_settings++;
    endtask

    // Random beat: mostly well-formed spreads and reads inside the grid, with spreads biased
    // toward the bottom row so heat climbs, a few row walks, and some out-of-range noise.
    task automatic queue_random_op(input int cols, input int rows);
        int pick;
        int row;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            queue_op(MODE_IGNITE, $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end else if (pick < 10) begin
            queue_op(MODE_DIM, $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end else if (pick < 70) begin
            row = (rows > 1 && $urandom_range(0, 1) == 1) ? rows - 1
                                                          : $urandom_range(0, rows - 1);
            queue_op(MODE_SPREAD, row, $urandom_range(0, cols - 1),
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)));
        end else if (pick < 90) begin
            queue_op(MODE_READ, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end else begin
            queue_op(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic run_random_phase(input logic [CFG_DW-1:0] cols, input logic [CFG_DW-1:0] rows,
                                    input int count);
        int cols_eff;
        int rows_eff;
        cols_eff = effective_count(cols, DEF_MAX_COLS);
        rows_eff = effective_count(rows, DEF_MAX_ROWS);
        set_grid(cols, rows);
        for (int k = 0; k < count; k++) queue_random_op(cols_eff, rows_eff);
        wait_drained();
    endtask

    // Stops a hung run.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        for (int m = 0; m < 4; m++) begin
            mode_count[m]   = 0;
            status_count[m] = 0;
        end
        for (int r = 0; r < DEF_MAX_ROWS; r++)
            for (int c = 0; c < DEF_MAX_COLS; c++)
                heat_grid[r][c] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Let the clearing pass get going before looking for an idle block.
        repeat (2) @(negedge i_clk);
        wait_drained();

        // Directed part on an 8 by 8 grid: ignite, all shifts including the edge rejections
        // and the meaningless shift, the top row, a cold source, and coordinates off the grid.
        set_grid(7'd8, 7'd8);
        queue_op(MODE_IGNITE, 0, 0, 1'b0, SHIFT_UP);
        queue_op(MODE_READ,   7, 0, 1'b0, SHIFT_UP);
        queue_op(MODE_SPREAD, 7, 3, 1'b0, SHIFT_UP);
        queue_op(MODE_SPREAD, 7, 0, 1'b0, SHIFT_LEFT);
        queue_op(MODE_SPREAD, 7, 7, 1'b1, SHIFT_RIGHT);
        queue_op(MODE_SPREAD, 7, 4, 1'b0, SHIFT_BAD);
        queue_op(MODE_SPREAD, 7, 0, 1'b1, SHIFT_RIGHT);
        queue_op(MODE_SPREAD, 7, 7, 1'b1, SHIFT_LEFT);
        queue_op(MODE_SPREAD, 6, 6, 1'b1, SHIFT_UP);
        queue_op(MODE_SPREAD, 0, 2, 1'b1, SHIFT_UP);
        queue_op(MODE_SPREAD, 4, 3, 1'b0, SHIFT_BAD);
        queue_op(MODE_READ,   8, 0, 1'b0, SHIFT_UP);
        queue_op(MODE_READ,   0, 8, 1'b0, SHIFT_UP);
        queue_op(MODE_READ,   63, 63, 1'b1, SHIFT_BAD);
        queue_op(MODE_SPREAD, 8, 2, 1'b0, SHIFT_UP);
        queue_op(MODE_READ,   6, 1, 1'b0, SHIFT_UP);
        queue_op(MODE_DIM,    0, 0, 1'b0, SHIFT_UP);
        queue_op(MODE_READ,   7, 2, 1'b0, SHIFT_UP);
        wait_drained();

        // Shrinking to 7 rows makes the row holding odd levels the bottom row, so repeated
        // dims step it through 1 and must stop at zero instead of wrapping.
        set_grid(7'd8, 7'd7);
        repeat (18) queue_op(MODE_DIM, 0, 0, 1'b0, SHIFT_UP);
        queue_op(MODE_READ, 6, 1, 1'b0, SHIFT_UP);
        wait_drained();

        // Growing back must leave the old bottom row untouched by those dims.
        set_grid(7'd8, 7'd8);
        queue_op(MODE_READ, 7, 2, 1'b0, SHIFT_UP);
        wait_drained();

        // Random part over several grid sizes, the register extremes among them.
        run_random_phase(7'd127, 7'd127, 50);
        run_random_phase(7'd0,   7'd0,   40);
        run_random_phase(7'd1,   7'd64,  50);
        run_random_phase(7'd64,  7'd1,   40);
        run_random_phase(7'd65,  7'd2,   50);
        run_random_phase(7'd3,   7'd100, 50);
        run_random_phase(7'd16,  7'd16,  60);
        run_random_phase(7'd2,   7'd2,   40);
        run_random_phase(CFG_DW'($urandom_range(1, 20)), CFG_DW'($urandom_range(1, 20)), 60);
        run_random_phase(CFG_DW'($urandom_range(1, 20)), CFG_DW'($urandom_range(1, 20)), 60);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("results still missing at end", 0, pending_results.size());

        $display("Covered %0d ignite, %0d dim, %0d spread and %0d read beats over %0d grid sizes.",
                 mode_count[MODE_IGNITE], mode_count[MODE_DIM], mode_count[MODE_SPREAD],
                 mode_count[MODE_READ], grid_settings);
        $display("Checked %0d results: %0d done, %0d shift rejected, %0d off the grid.",
                 results_seen, status_count[ST_DONE], status_count[ST_SHIFT_BAD],
                 status_count[ST_COORD_BAD]);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
